FILE: hdl/rme_pkg.sv
package rme_pkg;

  // datapath widths: vector components (30 fractional bits) and angles (24 fractional bits)
  localparam int XW = 36;
  localparam int ZW = 28;
  localparam int MAX_STEPS = 24;

  localparam logic signed [ZW-1:0] ANG_PI = 28'sd52707179;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic signed [16:0] OUT_LIMIT = 17'sd25736;

  typedef logic signed [XW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // round(atan(2^-i) * 2^24)
  function automatic ang_t atan_val(input int i);
    ang_t v;
    case (i)
      0: v = 28'sd13176795;
      1: v = 28'sd7778716;
      2: v = 28'sd4110060;
      3: v = 28'sd2086331;
      4: v = 28'sd1047214;
      5: v = 28'sd524117;
      6: v = 28'sd262123;
      7: v = 28'sd131069;
      8: v = 28'sd65536;
      9: v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.14 element to 30 fractional bits
  function automatic vec_t widen(input logic [15:0] r);
    return vec_t'({{(XW-32){r[15]}}, r, 16'b0});
  endfunction

endpackage

FILE: hdl/rme_cordic.sv
module rme_cordic import rme_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic ce,
  input  vec_t x_in,
  input  vec_t y_in,
  output ang_t z_out,
  output vec_t mag_out
);

  vec_t x [0:STEPS];
  vec_t y [0:STEPS];
  ang_t z [0:STEPS];
  logic zf [0:STEPS];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (ce) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= (y_in >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (ce) begin
        zf[i+1] <= zf[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_val(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_val(i);
        end
      end
    end
  end

  // zero vector gives angle zero
  assign z_out = zf[STEPS] ? '0 : z[STEPS];
  assign mag_out = x[STEPS];

endmodule

FILE: hdl/rotation_matrix_to_euler.sv
// Rotation matrix to x-y-z Euler angles. Seven Q2.14 elements go in on s_tdata,
// roll/pitch/yaw in Q3.13 radians come out on m_tdata, with m_tuser set when
// the gimbal-lock branch (sy below cfg_data threshold) was taken. Fully
// pipelined: one matrix per cycle, through two CORDIC pipelines in series
// (magnitude, then pitch) and a two-stage gain multiply. A stalled m_tready
// freezes the whole pipeline.
module rotation_matrix_to_euler import rme_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // r00_in, r10_in, r20_in, r21_in, r22_in, r11_in, r12_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic         m_tuser,  // is_singular
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data
);

  localparam int NS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT = 2 * (NS + 1) + 3;

  logic ce;
  logic [LAT-1:0] vld;
  logic [13:0] singular_threshold;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign cfg_ready = 1'b1;
  assign m_tvalid = vld[LAT-1];

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= 14'd1;
    end else if (cfg_valid) begin
      singular_threshold <= cfg_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // first CORDIC bank: magnitude/yaw and both roll candidates
  ang_t za, zb, zc;
  vec_t mag, mag_unused_b, mag_unused_c;

  rme_cordic #(.STEPS(NS)) u_yaw (
    .clk(clk), .ce(ce),
    .x_in(widen(s_tdata[15:0])), .y_in(widen(s_tdata[31:16])),
    .z_out(za), .mag_out(mag)
  );
  rme_cordic #(.STEPS(NS)) u_roll (
    .clk(clk), .ce(ce),
    .x_in(widen(s_tdata[79:64])), .y_in(widen(s_tdata[63:48])),
    .z_out(zb), .mag_out(mag_unused_b)
  );
  rme_cordic #(.STEPS(NS)) u_roll_lock (
    .clk(clk), .ce(ce),
    .x_in(widen(s_tdata[95:80])), .y_in(-widen(s_tdata[111:96])),
    .z_out(zc), .mag_out(mag_unused_c)
  );

  // r20 rides alongside the first bank
  logic [15:0] r20_d [0:NS];
  always_ff @(posedge clk) begin
    if (ce) begin
      r20_d[0] <= s_tdata[47:32];
      for (int i = 0; i < NS; i++) r20_d[i+1] <= r20_d[i];
    end
  end

  // gain multiply, two partial products then sum
  logic [32:0] p_lo, p_hi;
  ang_t m1_za, m1_zb, m1_zc, m2_za, m2_zb, m2_zc;
  logic [15:0] m1_r20, m2_r20;
  logic [33:0] sy;
  logic [49:0] sy_sum;

  assign sy_sum = {p_hi, 17'b0} + {17'b0, p_lo} + 50'd32768;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_lo <= {16'b0, mag[16:0]} * {17'b0, INV_GAIN};
      p_hi <= {16'b0, mag[33:17]} * {17'b0, INV_GAIN};
      m1_za <= za;
      m1_zb <= zb;
      m1_zc <= zc;
      m1_r20 <= r20_d[NS];
      sy <= sy_sum[49:16];
      m2_za <= m1_za;
      m2_zb <= m1_zb;
      m2_zc <= m1_zc;
      m2_r20 <= m1_r20;
    end
  end

  // branch select and pitch CORDIC
  logic sing;
  ang_t zp;
  vec_t mag_unused_p;

  assign sing = sy < {4'b0, singular_threshold, 16'b0};

  rme_cordic #(.STEPS(NS)) u_pitch (
    .clk(clk), .ce(ce),
    .x_in(vec_t'({2'b0, sy})), .y_in(-widen(m2_r20)),
    .z_out(zp), .mag_out(mag_unused_p)
  );

  ang_t roll_d [0:NS];
  ang_t yaw_d [0:NS];
  logic sing_d [0:NS];
  always_ff @(posedge clk) begin
    if (ce) begin
      roll_d[0] <= sing ? m2_zc : m2_zb;
      yaw_d[0] <= sing ? '0 : m2_za;
      sing_d[0] <= sing;
      for (int i = 0; i < NS; i++) begin
        roll_d[i+1] <= roll_d[i];
        yaw_d[i+1] <= yaw_d[i];
        sing_d[i+1] <= sing_d[i];
      end
    end
  end

  // round to Q3.13 and clamp
  function automatic logic [15:0] angle_out(input ang_t z);
    logic signed [ZW:0] s;
    logic signed [16:0] q;
    s = (ZW+1)'(z) + (ZW+1)'(1024);
    q = 17'(s >>> 11);
    if (q > OUT_LIMIT) q = OUT_LIMIT;
    if (q < -OUT_LIMIT) q = -OUT_LIMIT;
    return q[15:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {angle_out(yaw_d[NS]), angle_out(zp), angle_out(roll_d[NS])};
      m_tuser <= sing_d[NS];
    end
  end

endmodule

FILE: test/rotation_matrix_to_euler_tb.sv
module rotation_matrix_to_euler_tb import rme_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam longint PI_Q24 = 52707179;
  localparam longint GAIN_RECIP = 39797;
  localparam longint ANGLE_MAX = 25736;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               singular;
  } euler_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;  // r00, r10, r20, r21, r22, r11, r12
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;       // roll, pitch, yaw
  logic         m_tuser;       // is_singular
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [13:0]  cfg_data = '0;

  logic [111:0] matrix_q[$];
  euler_t       angles_q[$];
  logic [13:0]  gimbal_thr = 14'd1;
  bit           calm = 1'b0;
  int           errors = 0;
  int           cycles = 0;

  rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // vectoring rotation: angle in Q.24, magnitude through mag
  function automatic longint vector_angle(input longint xi, input longint yi,
                                          output longint mag);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    // left half plane: pre-rotate by pi
    if (x < 0) begin
      z = (y >= 0) ? PI_Q24 : -PI_Q24;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_val(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_val(i));
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic logic [15:0] to_q13(input longint z);
    longint q;
    q = (z + 1024) >>> 11;
    if (q > ANGLE_MAX) q = ANGLE_MAX;
    if (q < -ANGLE_MAX) q = -ANGLE_MAX;
    return q[15:0];
  endfunction

  function automatic euler_t matrix_to_angles(input logic [111:0] m, input logic [13:0] thr);
    longint r[7];
    longint mag, unused, sy, roll, pitch, yaw;
    euler_t e;
    for (int k = 0; k < 7; k++) r[k] = longint'($signed(m[16*k +: 16])) * 65536;
    void'(vector_angle(r[0], r[1], mag));
    sy = (mag * GAIN_RECIP + 32768) >>> 16;
    e.singular = sy < longint'(thr) * 65536;
    pitch = vector_angle(sy, -r[2], unused);
    if (!e.singular) begin
      roll = vector_angle(r[4], r[3], unused);
      yaw = vector_angle(r[0], r[1], unused);
    end else begin
      roll = vector_angle(r[5], -r[6], unused);
      yaw = 0;
    end
    e.roll = to_q13(roll);
    e.pitch = to_q13(pitch);
    e.yaw = to_q13(yaw);
    return e;
  endfunction

  function automatic logic [111:0] pack_matrix(input int r00, r10, r20, r21, r22, r11, r12);
    return {r12[15:0], r11[15:0], r22[15:0], r21[15:0], r20[15:0], r10[15:0], r00[15:0]};
  endfunction

  function automatic logic [15:0] rand_elem(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32768) - 16384);
      default: return 16'($urandom_range(2 * gimbal_thr + 8) - gimbal_thr - 4);
    endcase
  endfunction

  function automatic logic [111:0] rand_matrix();
    logic [111:0] m;
    int mode;
    mode = $urandom_range(3);
    for (int k = 0; k < 7; k++) m[16*k +: 16] = rand_elem(mode == 3 ? 1 : mode);
    // near gimbal lock: only r00/r10 stay small
    if (mode == 2) for (int k = 2; k < 7; k++) m[16*k +: 16] = rand_elem(1);
    return m;
  endfunction

  // append one request to the pending queue
  task automatic add_matrix(input logic [111:0] m);
    matrix_q = {matrix_q, m};
  endtask

  // stream driver
  always @(posedge clk) begin
    logic         nxt_valid;
    logic [111:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data = s_tdata;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        angles_q = {angles_q, matrix_to_angles(matrix_q.pop_front(), gimbal_thr)};
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && matrix_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
        nxt_valid = 1'b1;
        nxt_data = matrix_q[0];
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata <= nxt_data;
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    euler_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (angles_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        e = angles_q.pop_front();
        if (m_tdata[15:0] !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[31:16] !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, $signed(m_tdata[31:16]));
          errors++;
        end
        if (m_tdata[47:32] !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, $signed(m_tdata[47:32]));
          errors++;
        end
        if (m_tuser !== e.singular) begin
          $error("is_singular exp %0b got %0b", e.singular, m_tuser);
          errors++;
        end
      end
    end
    m_tready <= !rst && (calm || $urandom_range(99) >= 30);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (matrix_q.size() > 0 || angles_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [13:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    gimbal_thr = v;
  endtask

  task automatic random_requests(input int n);
    for (int i = 0; i < n; i++) add_matrix(rand_matrix());
  endtask

  initial begin
    logic [13:0] thr_list[5];
    thr_list = '{14'd0, 14'd16383, 14'd300, 14'd4000, 14'd9000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, identity, gimbal lock, left half plane, zero vector
    add_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 0));
    add_matrix(pack_matrix(16384, 0, 0, 0, 16384, 16384, 0));
    add_matrix(pack_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    add_matrix(pack_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    add_matrix(pack_matrix(32767, -32768, -32768, 32767, -32768, 32767, -32768));
    add_matrix(pack_matrix(0, 0, -16384, 16384, 0, 16384, 0));
    add_matrix(pack_matrix(0, 0, 16384, 0, 0, -16384, 16384));
    add_matrix(pack_matrix(-16384, 0, 0, 0, -16384, -16384, 0));
    add_matrix(pack_matrix(-16384, -1, 0, -1, -16384, -16384, 1));
    add_matrix(pack_matrix(-1, 1, 1, 1, -1, -1, -1));
    add_matrix(pack_matrix(11585, 11585, 0, 11585, 11585, 11585, 11585));
    add_matrix(pack_matrix(1, 0, 0, 0, 1, 1, 0));
    add_matrix(pack_matrix(0, 1, -1, 0, -1, 1, 1));
    add_matrix(pack_matrix(-32768, 0, 32767, -32768, 0, 0, 32767));
    add_matrix(pack_matrix(16383, -16384, 5000, -5000, 12000, -12000, 7));
    random_requests(60);
    drain();

    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      calm = (p == 2);
      random_requests(90);
      // hold off until all outstanding results are back
      drain();
      calm = 1'b0;
      random_requests(90);
      drain();
    end

    write_threshold(14'($urandom));
    random_requests(80);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: rotation_matrix_to_euler.f
hdl/rme_pkg.sv
hdl/rme_cordic.sv
hdl/rotation_matrix_to_euler.sv
test/rotation_matrix_to_euler_tb.sv
